// ===== rtl/core/llrc_pkg.sv =====
// ---------------------------------------------------------------------------
// llrc_pkg
// Shared constants for the laser line row center interpolator.
// ---------------------------------------------------------------------------
package llrc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int OUT_W = 13;
  localparam int GAP_W = 7;
  localparam int OFS_W = 12;
  localparam int PIX_W = 8;

  localparam int FILL_GAP_MAX = 64;
  localparam int FILL_GAP_MIN = 2;
  localparam int MAX_GAP_RESET = 20;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_MAX_GAP  = 2'd0;
  localparam reg_index_t REG_OFFSET_X = 2'd1;
  localparam reg_index_t REG_OFFSET_Y = 2'd2;

endpackage

// ===== rtl/core/llrc_ram.sv =====
// ---------------------------------------------------------------------------
// llrc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module llrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/laser_line_row_center_interpolate.sv =====
// ---------------------------------------------------------------------------
// laser_line_row_center_interpolate
// Picks the middle set pixel of each mask row as the laser point and fills
// short vertical gaps between points by exact integer interpolation.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// pixel     in         pixel_valid / pixel_ready    mask_pixel, row_end, frame_end
// point     out        point_valid / point_ready    point_x, point_y, last_point
// apb       in         psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// A pixel that does not end a row is taken every cycle while the block is idle.
// A row end with set pixels costs one column memory read, then for a filled
// gap a serial shift-subtract divide, one setup step and gap-1 fill points,
// then the detected point; a stalled point channel holds back each point.
// Reset is synchronous; the column memory needs no clearing pass.
// ---------------------------------------------------------------------------
module laser_line_row_center_interpolate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [llrc_pkg::PIX_W-1:0]  mask_pixel,
  input  logic                        row_end,
  input  logic                        frame_end,
  output logic                        point_valid,
  input  logic                        point_ready,
  output logic [llrc_pkg::OUT_W-1:0]  point_x,
  output logic [llrc_pkg::OUT_W-1:0]  point_y,
  output logic                        last_point,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llrc_pkg::ADDR_W-1:0] paddr,
  input  logic [llrc_pkg::DATA_W-1:0] pwdata,
  output logic [llrc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  import llrc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_LAST  = 3'd6;

  localparam int DIV_CNT_W = $clog2(COL_W + 1);

  logic [2:0]       state;
  logic [GAP_W-1:0] max_gap;
  logic [OFS_W-1:0] offset_x;
  logic [OFS_W-1:0] offset_y;

  logic [CNT_W-1:0] white_count;
  logic [CNT_W-1:0] column_counter;
  logic [ROW_W-1:0] row_counter;
  logic [COL_W-1:0] previous_x;
  logic [ROW_W-1:0] previous_y;
  logic             have_previous;

  logic [COL_W-1:0] mid_index;
  logic             frame_flag;
  logic [COL_W-1:0] cur_x;
  logic [ROW_W-1:0] cur_y;
  logic [GAP_W-1:0] gap;
  logic             dx_neg;
  logic [COL_W-1:0] div_num;
  logic [COL_W-1:0] div_quo;
  logic [GAP_W:0]   div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [COL_W:0] step_q;
  logic [GAP_W-1:0] step_r;
  logic [COL_W-1:0] fill_x;
  logic [GAP_W-1:0] fill_r;
  logic [GAP_W-1:0] fill_k;

  logic             pixel_accept;
  logic             row_done;
  logic             store_pixel;
  logic [CNT_W-1:0] white_count_next;
  logic             cfg_write;
  logic             slot_free;
  logic             point_load;
  logic [COL_W-1:0] ram_rdata;

  logic [GAP_W-1:0] gap_limit;
  logic [ROW_W-1:0] row_diff;
  logic             do_fill;
  logic signed [COL_W:0] dx;
  logic [GAP_W:0]   rem_shift;
  logic             rem_ge;
  logic [GAP_W:0]   r_sum;
  logic             r_carry;
  logic [GAP_W-1:0] fill_r_next;
  logic [COL_W+1:0] fill_x_sum;
  logic [GAP_W-1:0] fill_k_next;

  assign pready       = 1'b1;
  assign pixel_ready  = (state == S_IDLE);
  assign pixel_accept = pixel_valid && pixel_ready;
  assign row_done     = row_end || frame_end;
  assign cfg_write    = psel && penable && pwrite && pready;
  assign slot_free    = !point_valid || point_ready;
  assign point_load   = slot_free && ((state == S_FILL) || (state == S_LAST));

  assign store_pixel = (column_counter < CNT_W'(MAX_WIDTH)) && (mask_pixel != '0)
                       && (white_count < CNT_W'(MAX_WIDTH));
  assign white_count_next = store_pixel ? white_count + CNT_W'(1) : white_count;

  llrc_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_WIDTH)
  ) u_columns (
    .clk   (clk),
    .wen   (pixel_accept && store_pixel),
    .waddr (white_count[COL_W-1:0]),
    .wdata (column_counter[COL_W-1:0]),
    .ren   (state == S_READ),
    .raddr (mid_index),
    .rdata (ram_rdata)
  );

  assign gap_limit = (max_gap > GAP_W'(FILL_GAP_MAX)) ? GAP_W'(FILL_GAP_MAX) : max_gap;
  assign row_diff  = cur_y - previous_y;
  assign do_fill   = have_previous && (cur_y > previous_y)
                     && (row_diff >= ROW_W'(FILL_GAP_MIN))
                     && (row_diff <= ROW_W'(gap_limit));
  assign dx        = $signed({1'b0, ram_rdata}) - $signed({1'b0, previous_x});

  assign rem_shift = {div_rem[GAP_W-1:0], div_num[COL_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, gap};

  assign r_sum       = {1'b0, fill_r} + {1'b0, step_r};
  assign r_carry     = r_sum >= {1'b0, gap};
  assign fill_r_next = r_carry ? GAP_W'(r_sum - {1'b0, gap}) : r_sum[GAP_W-1:0];
  assign fill_x_sum  = $signed({2'b00, fill_x}) + (COL_W+2)'(step_q)
                       + (COL_W+2)'(r_carry);
  assign fill_k_next = fill_k + GAP_W'(1);

  always_comb begin
    case (paddr[3:2])
      REG_MAX_GAP:  prdata = DATA_W'(max_gap);
      REG_OFFSET_X: prdata = DATA_W'(offset_x);
      REG_OFFSET_Y: prdata = DATA_W'(offset_y);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap  <= GAP_W'(MAX_GAP_RESET);
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MAX_GAP:  max_gap  <= pwdata[GAP_W-1:0];
        REG_OFFSET_X: offset_x <= pwdata[OFS_W-1:0];
        REG_OFFSET_Y: offset_y <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      white_count    <= '0;
      column_counter <= '0;
      row_counter    <= '0;
      previous_x     <= '0;
      previous_y     <= '0;
      have_previous  <= 1'b0;
      point_valid    <= 1'b0;
    end else begin
      if (point_load) begin
        point_valid <= 1'b1;
      end else if (point_ready) begin
        point_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pixel_accept) begin
            if (row_done) begin
              white_count    <= '0;
              column_counter <= '0;
              cur_y          <= row_counter;
              frame_flag     <= frame_end;
              mid_index      <= white_count_next[COL_W:1];
              if (frame_end || (row_counter == ROW_W'(MAX_ROWS - 1))) begin
                row_counter <= '0;
              end else begin
                row_counter <= row_counter + ROW_W'(1);
              end
              if (white_count_next != '0) begin
                state <= S_READ;
              end else if (frame_end) begin
                have_previous <= 1'b0;
              end
            end else begin
              if (column_counter < CNT_W'(MAX_WIDTH)) begin
                column_counter <= column_counter + CNT_W'(1);
              end
              white_count <= white_count_next;
            end
          end
        end
        S_READ: begin
          state <= S_PICK;
        end
        S_PICK: begin
          cur_x   <= ram_rdata;
          gap     <= row_diff[GAP_W-1:0];
          dx_neg  <= dx[COL_W];
          div_num <= dx[COL_W] ? COL_W'(-dx) : dx[COL_W-1:0];
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= '0;
          state   <= do_fill ? S_DIV : S_LAST;
        end
        S_DIV: begin
          div_num <= {div_num[COL_W-2:0], 1'b0};
          div_quo <= {div_quo[COL_W-2:0], rem_ge};
          div_rem <= rem_ge ? rem_shift - {1'b0, gap} : rem_shift;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(COL_W - 1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (dx_neg && (div_rem != '0)) begin
            step_q <= -$signed({1'b0, div_quo}) - (COL_W+1)'(1);
            step_r <= gap - div_rem[GAP_W-1:0];
          end else if (dx_neg) begin
            step_q <= -$signed({1'b0, div_quo});
            step_r <= '0;
          end else begin
            step_q <= $signed({1'b0, div_quo});
            step_r <= div_rem[GAP_W-1:0];
          end
          fill_x <= previous_x;
          fill_r <= '0;
          fill_k <= '0;
          state  <= S_FILL;
        end
        S_FILL: begin
          if (slot_free) begin
            fill_x      <= fill_x_sum[COL_W-1:0];
            fill_r      <= fill_r_next;
            fill_k      <= fill_k_next;
            point_x     <= OUT_W'(fill_x_sum[COL_W-1:0]) + OUT_W'(offset_x);
            point_y     <= OUT_W'(previous_y + ROW_W'(fill_k_next)) + OUT_W'(offset_y);
            last_point  <= 1'b0;
            if (fill_k_next + GAP_W'(1) == gap) begin
              state <= S_LAST;
            end
          end
        end
        S_LAST: begin
          if (slot_free) begin
            point_x       <= OUT_W'(cur_x) + OUT_W'(offset_x);
            point_y       <= OUT_W'(cur_y) + OUT_W'(offset_y);
            last_point    <= 1'b1;
            previous_x    <= cur_x;
            previous_y    <= cur_y;
            have_previous <= !frame_flag;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
